### rtl/core/sphere_frustum_light_culler_macros.svh
// Assertion macros shared by the light culler RTL.
`ifndef SPHERE_FRUSTUM_LIGHT_CULLER_MACROS_SVH
`define SPHERE_FRUSTUM_LIGHT_CULLER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SFL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SFL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/sfl_pkg.sv
// Types and constants shared by the sphere/frustum light culler.
`timescale 1ns / 1ps
`default_nettype none

package sfl_pkg;

   localparam int LIGHT_LIMIT = 1024;
   localparam int FRAC_BITS   = 16;
   localparam int COUNT_W     = 11;
   localparam int SLOT_W      = 10;
   localparam int CSR_DATA_W  = 32;
   localparam int PROD_W      = 64;
   localparam int SUM_W       = 66;
   localparam int DEPTH_W     = 34;

   localparam logic [COUNT_W-1:0] LIGHT_LIMIT_C = COUNT_W'(LIGHT_LIMIT);
   localparam logic signed [SUM_W-1:0] ONE_SQ = SUM_W'(1) << (2 * FRAC_BITS);

   typedef enum logic [2:0] {
      CSR_PROJECTION_MODE = 3'd0,
      CSR_X_GAIN          = 3'd1,
      CSR_X_OFFSET        = 3'd2,
      CSR_Y_GAIN          = 3'd3,
      CSR_Y_OFFSET        = 3'd4,
      CSR_NEAR_DISTANCE   = 3'd5,
      CSR_FAR_DISTANCE    = 3'd6,
      CSR_MAX_LIGHTS      = 3'd7
   } csr_index_type;

   typedef enum logic {
      PROJ_PERSPECTIVE = 1'b0,
      PROJ_ORTHOGRAPHIC = 1'b1
   } proj_mode_type;

   typedef enum logic [1:0] {
      KIND_POINT       = 2'd0,
      KIND_DIRECTIONAL = 2'd1,
      KIND_SPOT        = 2'd2
   } light_kind_type;

   typedef struct packed {
      logic [1:0]         light_kind;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0]        radius;
      logic               frame_end;
   } req_type;

   typedef struct packed {
      logic              keep;
      logic [SLOT_W-1:0] slot;
      logic              frame_done;
   } rsp_type;

   typedef struct packed {
      proj_mode_type      projection_mode;
      logic signed [31:0] x_gain;
      logic signed [31:0] x_offset;
      logic signed [31:0] y_gain;
      logic signed [31:0] y_offset;
      logic [30:0]        near_distance;
      logic [30:0]        far_distance;
      logic [COUNT_W-1:0] max_lights;
   } cfg_type;

   // Products and side data carried from the multiply stage to the test.
   typedef struct packed {
      logic signed [PROD_W-1:0] gain_cx;
      logic signed [PROD_W-1:0] gain_cy;
      logic signed [PROD_W-1:0] cz_xoff;
      logic signed [PROD_W-1:0] cz_yoff;
      logic signed [PROD_W-1:0] xgain_r;
      logic signed [PROD_W-1:0] ygain_r;
      logic                     neg_x;
      logic                     neg_y;
      logic signed [31:0]       center_z;
      logic [30:0]              radius;
      logic [1:0]               light_kind;
      logic                     frame_end;
   } prod_type;

endpackage

`default_nettype wire

### rtl/core/sfl_csr.sv
// Configuration register file of the light culler.
`timescale 1ns / 1ps
`default_nettype none

module sfl_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write,
   input  wire sfl_pkg::csr_index_type       csr_index,
   input  wire logic [sfl_pkg::CSR_DATA_W-1:0] csr_data,
   output sfl_pkg::cfg_type                  cfg
);
   import sfl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PROJECTION_MODE: cfg_in.projection_mode = proj_mode_type'(csr_data[0]);
            CSR_X_GAIN:          cfg_in.x_gain = $signed(csr_data);
            CSR_X_OFFSET:        cfg_in.x_offset = $signed(csr_data);
            CSR_Y_GAIN:          cfg_in.y_gain = $signed(csr_data);
            CSR_Y_OFFSET:        cfg_in.y_offset = $signed(csr_data);
            CSR_NEAR_DISTANCE:   cfg_in.near_distance = csr_data[30:0];
            CSR_FAR_DISTANCE:    cfg_in.far_distance = csr_data[30:0];
            CSR_MAX_LIGHTS:      cfg_in.max_lights = csr_data[COUNT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.projection_mode <= PROJ_PERSPECTIVE;
         cfg_ff.x_gain          <= 32'sd65536;
         cfg_ff.x_offset        <= 32'sd0;
         cfg_ff.y_gain          <= 32'sd65536;
         cfg_ff.y_offset        <= 32'sd0;
         cfg_ff.near_distance   <= 31'd6554;
         cfg_ff.far_distance    <= 31'd65536000;
         cfg_ff.max_lights      <= LIGHT_LIMIT_C;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/core/sfl_prod.sv
// Multiply stage: the six plane products of one light, registered.
`timescale 1ns / 1ps
`default_nettype none

module sfl_prod (
   input  wire logic             clock,
   input  wire logic             load,
   input  wire sfl_pkg::req_type item,
   input  wire sfl_pkg::cfg_type cfg,
   output sfl_pkg::prod_type     prod
);
   import sfl_pkg::*;

   prod_type           prod_ff;
   prod_type           prod_in;
   logic signed [31:0] rad_s;

   // The radius is non-negative, so a zero sign bit makes it a signed operand.
   assign rad_s = $signed({1'b0, item.radius});

   always_comb begin
      prod_in.gain_cx    = cfg.x_gain * item.center_x;
      prod_in.gain_cy    = cfg.y_gain * item.center_y;
      prod_in.cz_xoff    = item.center_z * cfg.x_offset;
      prod_in.cz_yoff    = item.center_z * cfg.y_offset;
      prod_in.xgain_r    = cfg.x_gain * rad_s;
      prod_in.ygain_r    = cfg.y_gain * rad_s;
      prod_in.neg_x      = item.center_x[31];
      prod_in.neg_y      = item.center_y[31];
      prod_in.center_z   = item.center_z;
      prod_in.radius     = item.radius;
      prod_in.light_kind = item.light_kind;
      prod_in.frame_end  = item.frame_end;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

### rtl/core/sfl_judge.sv
// Frustum and depth test on the registered products of one light.
`timescale 1ns / 1ps
`default_nettype none

module sfl_judge (
   input  wire sfl_pkg::prod_type prod,
   input  wire sfl_pkg::cfg_type  cfg,
   output logic                   pass
);
   import sfl_pkg::*;

   // gain*|c| + z*offset < radius, with gain*|c| formed from gain*c.
   function automatic logic persp_axis(input logic signed [PROD_W-1:0] gain_c,
                                       input logic neg,
                                       input logic signed [PROD_W-1:0] z_off,
                                       input logic [30:0] r);
      logic signed [SUM_W-1:0] mag;
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] lim;
      mag = neg ? -SUM_W'(gain_c) : SUM_W'(gain_c);
      sum = mag + SUM_W'(z_off);
      lim = SUM_W'($signed({1'b0, r})) <<< FRAC_BITS;
      return sum < lim;
   endfunction

   // |gain*c + bias| < 1 + gain*radius, all at the product scale.
   function automatic logic ortho_axis(input logic signed [PROD_W-1:0] gain_c,
                                       input logic signed [31:0] bias,
                                       input logic signed [PROD_W-1:0] gain_r);
      logic signed [SUM_W-1:0] a;
      logic signed [SUM_W-1:0] a_abs;
      logic signed [SUM_W-1:0] b;
      a     = SUM_W'(gain_c) + (SUM_W'(bias) <<< FRAC_BITS);
      a_abs = a[SUM_W-1] ? -a : a;
      b     = ONE_SQ + SUM_W'(gain_r);
      return a_abs < b;
   endfunction

   logic                      axes_ok;
   logic                      depth_ok;
   logic signed [DEPTH_W-1:0] z_s;
   logic signed [DEPTH_W-1:0] r_s;
   logic signed [DEPTH_W-1:0] near_s;
   logic signed [DEPTH_W-1:0] far_s;

   assign z_s    = DEPTH_W'(prod.center_z);
   assign r_s    = $signed({3'b000, prod.radius});
   assign near_s = $signed({3'b000, cfg.near_distance});
   assign far_s  = $signed({3'b000, cfg.far_distance});

   always_comb begin
      if (cfg.projection_mode == PROJ_PERSPECTIVE) begin
         axes_ok = persp_axis(prod.gain_cx, prod.neg_x, prod.cz_xoff, prod.radius) &&
                   persp_axis(prod.gain_cy, prod.neg_y, prod.cz_yoff, prod.radius);
      end else begin
         axes_ok = ortho_axis(prod.gain_cx, cfg.x_offset, prod.xgain_r) &&
                   ortho_axis(prod.gain_cy, cfg.y_offset, prod.ygain_r);
      end
      depth_ok = ((z_s - r_s) <= -near_s) && ((z_s + r_s) >= -far_s);
      // Only point lights are tested; every other kind passes.
      pass = (prod.light_kind != KIND_POINT) || (axes_ok && depth_ok);
   end

endmodule

`default_nettype wire

### rtl/core/sphere_frustum_light_culler.sv
// Path: an accepted request beat passes the input, product and result registers to its response beat.
// Throughput: one light per cycle without rsp_stall; those registers each hold a beat.
// The product stage sets the figure: six 32 by 32 multipliers run side by side each cycle.
// Reset (synchronous) empties the pipeline, clears the kept count and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "sphere_frustum_light_culler_macros.svh"

module sphere_frustum_light_culler (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire sfl_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output sfl_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_write,
   input  wire sfl_pkg::csr_index_type         csr_index,
   input  wire logic [sfl_pkg::CSR_DATA_W-1:0] csr_data
);
   import sfl_pkg::*;

   cfg_type            cfg;
   prod_type           prod;
   logic               pass;

   logic               s1_valid_ff;
   req_type            s1_item_ff;
   logic               s2_valid_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] cap;
   logic               keep;

   logic               adv1;
   logic               adv2;
   logic               adv3;
   logic               retire;

   // Each stage moves when it is empty or the stage after it moves.
   assign adv3   = !rsp_valid_ff || !rsp_stall;
   assign adv2   = !s2_valid_ff || adv3;
   assign adv1   = !s1_valid_ff || adv2;
   assign retire = adv3 && s2_valid_ff;

   assign req_stall = !adv1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   sfl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfl_prod u_prod (
      .clock (clock),
      .load  (adv2 && s1_valid_ff),
      .item  (s1_item_ff),
      .cfg   (cfg),
      .prod  (prod)
   );

   sfl_judge u_judge (
      .prod (prod),
      .cfg  (cfg),
      .pass (pass)
   );

   always_comb begin
      cap  = (cfg.max_lights < LIGHT_LIMIT_C) ? cfg.max_lights : LIGHT_LIMIT_C;
      keep = pass && (count_ff < cap);
      rsp_in.keep       = keep;
      rsp_in.slot       = keep ? count_ff[SLOT_W-1:0] : '0;
      rsp_in.frame_done = prod.frame_end;
      count_in = count_ff;
      if (retire) begin
         if (prod.frame_end) begin
            count_in = '0;
         end else if (keep) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_valid) begin
         s1_item_ff <= req_data;
      end
      if (retire) begin
         rsp_ff <= rsp_in;
      end
   end

   `SFL_ASSERT(a_count_bounded, clock, reset, count_ff <= LIGHT_LIMIT_C, "kept count above limit")
   `SFL_ASSERT(a_slot_matches_count, clock, reset, (retire && keep && !prod.frame_end) |=> (count_ff == (COUNT_W'(rsp_ff.slot) + 1'b1)), "kept slot and count disagree")
   `SFL_ASSERT(a_frame_clears, clock, reset, (retire && prod.frame_end) |=> (count_ff == '0), "count not cleared at frame end")
   `SFL_ASSERT_ALWAYS(a_stall_only_full, clock, req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff && rsp_stall), "request stalled with room in the pipeline")

endmodule

`default_nettype wire
